// File: design/lfcg_pkg.sv
// ----------------------------------------------------------------------------
// lfcg_pkg: shared types and constants for the LCD field capture block
// Function codes, start-up phases, default sizes and the stage control
// group that travels from the capture control to the frame store.
// ----------------------------------------------------------------------------
`default_nettype none

package lfcg_pkg;

    localparam int unsigned GROUPS_PER_FRAME_DFLT = 6400;
    localparam int unsigned FIELDS_PER_FRAME_DFLT = 3;

    localparam int unsigned FUNC_W        = 2;
    localparam int unsigned PIXELS_W      = 4;
    localparam int unsigned READ_GROUP_W  = 13;
    localparam int unsigned GROUP_DATA_W  = 8;
    localparam int unsigned FIELD_W       = 2;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_DONE   = 2'd1,
        FUNC_READ   = 2'd2
    } lfcg_func_t;

    typedef enum logic [1:0] {
        PHASE_WAIT_LOW  = 2'd0,
        PHASE_WAIT_HIGH = 2'd1,
        PHASE_RUN       = 2'd2
    } lfcg_phase_t;

    // what the store does with the item in its second stage
    typedef struct packed {
        logic write;       // merge pixel bits into the addressed group
        logic accumulate;  // add to the stored shades instead of setting them
        logic read_out;    // present the addressed group as group_data
    } lfcg_op_t;

endpackage

`default_nettype wire

// File: design/lfcg_store.sv
// ----------------------------------------------------------------------------
// lfcg_store: frame store with read-modify-write of pixel groups
// Two frame buffers in one synchronous memory. An issued item reads its group;
// when the item commits, the group is merged with the pixel bits and written back,
// or handed out for a display read. Back-to-back hits on one group forward.
// ----------------------------------------------------------------------------
`default_nettype none

module lfcg_store #(
    parameter  int unsigned GROUPS_PER_FRAME = lfcg_pkg::GROUPS_PER_FRAME_DFLT,
    localparam int unsigned ADDR_W           = $clog2(2 * GROUPS_PER_FRAME)
) (
    input  wire logic                               aclk,
    input  wire logic                               issue,
    input  wire lfcg_pkg::lfcg_op_t                 op,
    input  wire logic [ADDR_W-1:0]                  addr,
    input  wire logic [lfcg_pkg::PIXELS_W-1:0]      pixel_bits,
    input  wire logic                               commit,
    output logic [lfcg_pkg::GROUP_DATA_W-1:0]       group_data
);
    import lfcg_pkg::*;

    localparam int unsigned DEPTH = 2 * GROUPS_PER_FRAME;

    logic [GROUP_DATA_W-1:0] mem [DEPTH];

    lfcg_op_t                op_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic [PIXELS_W-1:0]     bits_reg;
    logic [GROUP_DATA_W-1:0] rdata_reg;
    logic                    fwd_hit_reg;
    logic [GROUP_DATA_W-1:0] fwd_data_reg;

    logic [GROUP_DATA_W-1:0] old_data;
    logic [GROUP_DATA_W-1:0] wdata;

    assign old_data = fwd_hit_reg ? fwd_data_reg : rdata_reg;

    always_comb begin
        logic [2:0] shade;
        wdata = '0;
        shade = '0;
        for (int p = 0; p < PIXELS_W; p++) begin
            if (op_reg.accumulate) begin
                shade = {1'b0, old_data[2*p +: 2]} + {2'b00, bits_reg[p]};
                wdata[2*p +: 2] = shade[2] ? 2'd3 : shade[1:0];
            end else begin
                wdata[2*p +: 2] = {1'b0, bits_reg[p]};
            end
        end
    end

    assign group_data = op_reg.read_out ? old_data : '0;

    always_ff @(posedge aclk) begin
        if (commit && op_reg.write) begin
            mem[addr_reg] <= wdata;
        end
    end

    // memory reads old data on a same-cycle write; the forward path covers it
    always_ff @(posedge aclk) begin
        if (issue) begin
            op_reg       <= op;
            addr_reg     <= addr;
            bits_reg     <= pixel_bits;
            rdata_reg    <= mem[addr];
            fwd_hit_reg  <= commit && op_reg.write && (addr_reg == addr);
            fwd_data_reg <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: design/lcd_field_capture_grayscale_top.sv
// ----------------------------------------------------------------------------
// lcd_field_capture_grayscale_top: LCD pin capture with 2-bit shade buildup
// Tracks pixel clock and frame polarity edges, accumulates fields into the
// back buffer, swaps buffers at frame end and serves display buffer reads.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  --------+-----------+--------------------------------------------------------
//  s_      | in        | s_valid s_ready s_func s_pixel_clock s_frame_polarity
//          |           | s_pixel_bits s_read_group
//  m_      | out       | m_valid m_ready m_group_data m_display_buffer
//          |           | m_frame_ready m_field_number m_flipped
//
//  One item per cycle sustained while m_ready is high; each accepted item
//  passes the frame store read stage, then the output register. Control
//  state updates at acceptance; the frame store read-modify-write completes
//  as the item leaves the read stage, with forwarding between adjacent items.
//  Reset clears control state only; the 2*GROUPS_PER_FRAME entry store is
//  not cleared. A stalled m_ channel holds s_ready low once both stages fill.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_field_capture_grayscale_top #(
    parameter int unsigned GROUPS_PER_FRAME = lfcg_pkg::GROUPS_PER_FRAME_DFLT,
    parameter int unsigned FIELDS_PER_FRAME = lfcg_pkg::FIELDS_PER_FRAME_DFLT
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [lfcg_pkg::FUNC_W-1:0]       s_func,
    input  wire logic                              s_pixel_clock,
    input  wire logic                              s_frame_polarity,
    input  wire logic [lfcg_pkg::PIXELS_W-1:0]     s_pixel_bits,
    input  wire logic [lfcg_pkg::READ_GROUP_W-1:0] s_read_group,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [lfcg_pkg::GROUP_DATA_W-1:0]      m_group_data,
    output logic                                   m_display_buffer,
    output logic                                   m_frame_ready,
    output logic [lfcg_pkg::FIELD_W-1:0]           m_field_number,
    output logic                                   m_flipped
);
    import lfcg_pkg::*;

    localparam int unsigned WG_W   = $clog2(GROUPS_PER_FRAME + 1);
    localparam int unsigned ADDR_W = $clog2(2 * GROUPS_PER_FRAME);
    localparam int unsigned CMP_W  = (WG_W > READ_GROUP_W) ? WG_W : READ_GROUP_W;

    // control state
    lfcg_phase_t          phase_reg, phase_next;
    logic                 prev_clock_reg, prev_clock_next;
    logic                 prev_pol_reg, prev_pol_next;
    logic [FIELD_W-1:0]   field_reg, field_next;
    logic [WG_W-1:0]      wgroup_reg, wgroup_next;
    logic                 shown_reg, shown_next;
    logic                 ready_reg, ready_next;

    // pipeline
    logic                 b_valid_reg;
    logic                 b_shown_reg, b_ready_reg, b_flipped_reg;
    logic [FIELD_W-1:0]   b_field_reg;
    logic                 c_valid_reg;
    logic [GROUP_DATA_W-1:0] c_data_reg;
    logic                 c_shown_reg, c_ready_reg, c_flipped_reg;
    logic [FIELD_W-1:0]   c_field_reg;

    logic                 accept;
    logic                 b_adv;
    logic                 commit;
    logic                 flipped;
    lfcg_op_t             op;
    logic                 sel_buf;
    logic [WG_W-1:0]      grp;
    logic [ADDR_W-1:0]    mem_addr;
    logic [GROUP_DATA_W-1:0] store_data;

    assign b_adv   = !c_valid_reg || m_ready;
    assign s_ready = !b_valid_reg || b_adv;
    assign accept  = s_valid && s_ready;
    assign commit  = b_valid_reg && b_adv;

    assign mem_addr = (sel_buf ? ADDR_W'(GROUPS_PER_FRAME) : '0) + ADDR_W'(grp);

    always_comb begin
        logic pix_edge;
        phase_next      = phase_reg;
        prev_clock_next = prev_clock_reg;
        prev_pol_next   = prev_pol_reg;
        field_next      = field_reg;
        wgroup_next     = wgroup_reg;
        shown_next      = shown_reg;
        ready_next      = ready_reg;
        flipped         = 1'b0;
        op              = '0;
        sel_buf         = ~shown_reg;
        grp             = wgroup_reg;
        pix_edge        = s_pixel_clock && !prev_clock_reg;

        if (accept) begin
            unique case (lfcg_func_t'(s_func))
                FUNC_SAMPLE: begin
                    unique case (phase_reg)
                        PHASE_WAIT_LOW: begin
                            if (!s_frame_polarity) begin
                                phase_next = PHASE_WAIT_HIGH;
                            end
                        end
                        PHASE_WAIT_HIGH: begin
                            if (s_frame_polarity) begin
                                phase_next      = PHASE_RUN;
                                prev_clock_next = 1'b0;
                                prev_pol_next   = 1'b1;
                                field_next      = '0;
                                wgroup_next     = '0;
                            end
                        end
                        PHASE_RUN: begin
                            if (pix_edge && (wgroup_reg < WG_W'(GROUPS_PER_FRAME))) begin
                                op.write      = 1'b1;
                                op.accumulate = (field_reg != '0);
                                wgroup_next   = wgroup_reg + 1'b1;
                            end
                            // field change after the write: rewind, maybe swap
                            if (s_frame_polarity != prev_pol_reg) begin
                                if (({1'b0, field_reg} + 3'd1) >= 3'(FIELDS_PER_FRAME)) begin
                                    if (!ready_reg) begin
                                        shown_next = ~shown_reg;
                                        ready_next = 1'b1;
                                        flipped    = 1'b1;
                                    end
                                    field_next = '0;
                                end else begin
                                    field_next = field_reg + 1'b1;
                                end
                                wgroup_next = '0;
                            end
                            prev_clock_next = s_pixel_clock;
                            prev_pol_next   = s_frame_polarity;
                        end
                        default: begin
                            phase_next = PHASE_WAIT_LOW;
                        end
                    endcase
                end
                FUNC_DONE: begin
                    ready_next = 1'b0;
                end
                FUNC_READ: begin
                    sel_buf     = shown_reg;
                    grp         = WG_W'(s_read_group);
                    op.read_out = CMP_W'(s_read_group) < CMP_W'(GROUPS_PER_FRAME);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_WAIT_LOW;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_clock_reg <= 1'b0;
            prev_pol_reg   <= 1'b1;
            field_reg      <= '0;
            wgroup_reg     <= '0;
            shown_reg      <= 1'b0;
            ready_reg      <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
        end else begin
            prev_clock_reg <= prev_clock_next;
            prev_pol_reg   <= prev_pol_next;
            field_reg      <= field_next;
            wgroup_reg     <= wgroup_next;
            shown_reg      <= shown_next;
            ready_reg      <= ready_next;
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_shown_reg   <= shown_next;
            b_ready_reg   <= ready_next;
            b_field_reg   <= field_next;
            b_flipped_reg <= flipped;
        end
        if (commit) begin
            c_data_reg    <= store_data;
            c_shown_reg   <= b_shown_reg;
            c_ready_reg   <= b_ready_reg;
            c_field_reg   <= b_field_reg;
            c_flipped_reg <= b_flipped_reg;
        end
    end

    lfcg_store #(
        .GROUPS_PER_FRAME (GROUPS_PER_FRAME)
    ) u_store (
        .aclk       (aclk),
        .issue      (accept),
        .op         (op),
        .addr       (mem_addr),
        .pixel_bits (s_pixel_bits),
        .commit     (commit),
        .group_data (store_data)
    );

    assign m_valid          = c_valid_reg;
    assign m_group_data     = c_data_reg;
    assign m_display_buffer = c_shown_reg;
    assign m_frame_ready    = c_ready_reg;
    assign m_field_number   = c_field_reg;
    assign m_flipped        = c_flipped_reg;

`ifndef SYNTHESIS
    // a swap always raises the busy flag
    a_flip_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_flipped) |-> m_frame_ready)
        else $error("swap reported without frame_ready");

    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (3'(m_field_number) < 3'(FIELDS_PER_FRAME)))
        else $error("field number out of range");

    a_wgroup_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wgroup_reg <= WG_W'(GROUPS_PER_FRAME))
        else $error("write pointer past end of buffer");

    // a free slot in either stage must let an item in
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!b_valid_reg || !c_valid_reg) |-> s_ready)
        else $error("input stalled with pipeline space free");

    // buffer index only changes on a reported swap
    a_swap_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (shown_reg != $past(shown_reg)) |-> $past(accept && flipped))
        else $error("buffer index changed without swap");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: LCD field capture with 2-bit shade buildup
// Drives pin samples, renderer-done and buffer-read items through the s_
// channel and checks every m_ status item against a cycle-free predictor of
// the capture state and both frame buffers. The frame is shrunk to a few
// dozen groups so that full fields, write overflow and many swaps occur.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import lfcg_pkg::*;

    localparam int GROUPS        = 24;
    localparam int FIELDS        = 3;
    localparam int RANDOM_ITEMS  = 500;
    localparam int LIMIT         = 300000;
    localparam int GROUP_MAX     = (1 << READ_GROUP_W) - 1;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic                    clk;
        logic                    pol;
        logic [PIXELS_W-1:0]     pixels;
        logic [READ_GROUP_W-1:0] read_group;
    } capture_item_t;

    typedef struct packed {
        logic [GROUP_DATA_W-1:0] group_data;
        logic                    display_buffer;
        logic                    frame_ready;
        logic [FIELD_W-1:0]      field_number;
        logic                    flipped;
    } capture_status_t;

    typedef struct {
        capture_item_t   item;
        capture_status_t status;
        bit              drain;   // wait for all results before offering
    } queued_item_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic [FUNC_W-1:0]       s_func           = '0;
    logic                    s_pixel_clock    = 1'b0;
    logic                    s_frame_polarity = 1'b0;
    logic [PIXELS_W-1:0]     s_pixel_bits     = '0;
    logic [READ_GROUP_W-1:0] s_read_group     = '0;

    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [GROUP_DATA_W-1:0] m_group_data;
    logic                    m_display_buffer;
    logic                    m_frame_ready;
    logic [FIELD_W-1:0]      m_field_number;
    logic                    m_flipped;

    lcd_field_capture_grayscale_top #(
        .GROUPS_PER_FRAME (GROUPS),
        .FIELDS_PER_FRAME (FIELDS)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_pixel_clock    (s_pixel_clock),
        .s_frame_polarity (s_frame_polarity),
        .s_pixel_bits     (s_pixel_bits),
        .s_read_group     (s_read_group),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_group_data     (m_group_data),
        .m_display_buffer (m_display_buffer),
        .m_frame_ready    (m_frame_ready),
        .m_field_number   (m_field_number),
        .m_flipped        (m_flipped)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // capture state as seen by the predictor
    // ------------------------------------------------------------------
    lfcg_phase_t        cap_phase  = PHASE_WAIT_LOW;
    logic               clk_last   = 1'b0;
    logic               pol_last   = 1'b1;
    logic [FIELD_W-1:0] field_idx  = '0;
    int                 write_ptr  = 0;
    logic               front_buf  = 1'b0;
    logic               busy       = 1'b0;
    logic [7:0]         shades [0:2*GROUPS-1];
    bit                 filled [0:2*GROUPS-1];

    queued_item_t    item_q[$];
    capture_status_t awaited_status[$];
    queued_item_t    cur;
    bit              drain_next = 1'b0;

    int  errors       = 0;
    int  accepted     = 0;
    int  results_seen = 0;
    int  cycles       = 0;
    bit  taken        = 1'b0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    logic hold_active = 1'b0;

    function automatic int back_base();
        return front_buf ? 0 : GROUPS;
    endfunction

    function automatic int front_base();
        return front_buf ? GROUPS : 0;
    endfunction

    // one item in, one status item out
    function automatic capture_status_t advance_capture(capture_item_t it);
        capture_status_t st;
        int addr;
        int shade;
        int p;
        logic [7:0] merged;
        st = '0;
        case (it.func)
            FUNC_SAMPLE: begin
                if (cap_phase == PHASE_WAIT_LOW) begin
                    if (!it.pol) cap_phase = PHASE_WAIT_HIGH;
                end else if (cap_phase == PHASE_WAIT_HIGH) begin
                    if (it.pol) begin
                        cap_phase = PHASE_RUN;
                        clk_last  = 1'b0;
                        pol_last  = 1'b1;
                        field_idx = '0;
                        write_ptr = 0;
                    end
                end else begin
                    // group is written before a polarity change takes effect
                    if (it.clk && !clk_last && write_ptr < GROUPS) begin
                        addr = back_base() + write_ptr;
                        for (p = 0; p < 4; p++) begin
                            if (field_idx == 0) shade = it.pixels[p];
                            else shade = shades[addr][2*p +: 2] + it.pixels[p];
                            if (shade > 3) shade = 3;
                            merged[2*p +: 2] = 2'(shade);
                        end
                        shades[addr] = merged;
                        filled[addr] = 1'b1;
                        write_ptr++;
                    end
                    if (it.pol != pol_last) begin
                        if (int'(field_idx) + 1 >= FIELDS) begin
                            if (!busy) begin
                                front_buf  = ~front_buf;
                                busy       = 1'b1;
                                st.flipped = 1'b1;
                            end
                            field_idx = '0;
                        end else begin
                            field_idx = field_idx + 1'b1;
                        end
                        write_ptr = 0;
                    end
                    clk_last = it.clk;
                    pol_last = it.pol;
                end
            end
            FUNC_DONE: busy = 1'b0;
            FUNC_READ: begin
                if (it.read_group < GROUPS)
                    st.group_data = shades[front_base() + int'(it.read_group)];
            end
            default: ;
        endcase
        st.display_buffer = front_buf;
        st.frame_ready    = busy;
        st.field_number   = field_idx;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    function automatic capture_item_t rand_item(logic [FUNC_W-1:0] func);
        capture_item_t it;
        it.func       = func;
        it.clk        = 1'($urandom);
        it.pol        = 1'($urandom);
        it.pixels     = PIXELS_W'($urandom);
        it.read_group = READ_GROUP_W'($urandom);
        return it;
    endfunction

    task automatic queue_item(capture_item_t it);
        queued_item_t q;
        q.item     = it;
        q.status   = advance_capture(it);
        q.drain    = drain_next;
        drain_next = 1'b0;
        item_q.push_back(q);
    endtask

    // a rising edge that would add onto a never-written group is held low
    task automatic pin_sample(logic clk, logic pol, logic [PIXELS_W-1:0] bits);
        capture_item_t it;
        int addr;
        addr = back_base() + write_ptr;
        if (cap_phase == PHASE_RUN && clk && !clk_last && field_idx != 0 &&
            write_ptr < GROUPS && !filled[addr])
            clk = 1'b0;
        it        = rand_item(FUNC_SAMPLE);
        it.clk    = clk;
        it.pol    = pol;
        it.pixels = bits;
        queue_item(it);
    endtask

    // unwritten groups of the shown buffer are never read
    task automatic read_group_at(int idx);
        capture_item_t it;
        if (idx < GROUPS && !filled[front_base() + idx])
            idx = $urandom_range(GROUPS, GROUP_MAX);
        it            = rand_item(FUNC_READ);
        it.read_group = READ_GROUP_W'(idx);
        queue_item(it);
    endtask

    task automatic rand_read();
        if ($urandom_range(0, 3) == 0) read_group_at($urandom_range(0, GROUP_MAX));
        else read_group_at($urandom_range(0, GROUPS - 1));
    endtask

    task automatic capture_field(int edges);
        logic pol;
        int i;
        pol = pol_last;
        for (i = 0; i < edges; i++) begin
            pin_sample(1'b0, pol, PIXELS_W'($urandom));
            if ($urandom_range(0, 5) == 0) pin_sample(1'b0, pol, PIXELS_W'($urandom));
            pin_sample(1'b1, pol, PIXELS_W'($urandom));
            if ($urandom_range(0, 7) == 0) rand_read();
        end
        if ($urandom_range(0, 2) == 0) begin
            pin_sample(1'b0, pol, PIXELS_W'($urandom));
            pin_sample(1'b1, ~pol, PIXELS_W'($urandom));
        end else begin
            pin_sample(1'($urandom), ~pol, PIXELS_W'($urandom));
        end
        // renderer usually picks up a fresh frame soon
        if (busy && $urandom_range(0, 3) != 0) begin
            rand_read();
            rand_read();
            queue_item(rand_item(FUNC_DONE));
        end
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit calm();
        return accepted >= 350 && accepted < 420;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("result %0d: %s is %0h, expected %0h", results_seen, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            awaited_status.push_back(cur.status);
            accepted++;
            taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || taken) begin
            if (taken) begin
                taken    = 1'b0;
                gap_left = (calm() || hold_active) ? 0 : idle_len();
            end
            if (gap_left != 0 && !hold_active) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (item_q.size() == 0 ||
                         (item_q[0].drain && awaited_status.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                cur = item_q.pop_front();
                s_valid          <= 1'b1;
                s_func           <= cur.item.func;
                s_pixel_clock    <= cur.item.clk;
                s_frame_polarity <= cur.item.pol;
                s_pixel_bits     <= cur.item.pixels;
                s_read_group     <= cur.item.read_group;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus one long hold to back up the pipeline
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            hold_active <= (hold_left != 0);
            m_ready     <= 1'b0;
        end else if (!hold_done && accepted >= 150) begin
            hold_done   = 1'b1;
            hold_left   = 80;
            hold_active <= 1'b1;
            m_ready     <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            stall_left = (calm() || $urandom_range(0, 2) != 0) ? 0 : idle_len();
            m_ready <= (stall_left == 0);
        end
    end

    always @(posedge aclk) begin
        capture_status_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (awaited_status.size() == 0) begin
                report_mismatch("unexpected item, group_data", m_group_data, 0);
            end else begin
                want = awaited_status.pop_front();
                if (m_group_data !== want.group_data)
                    report_mismatch("group_data", m_group_data, want.group_data);
                if (m_display_buffer !== want.display_buffer)
                    report_mismatch("display_buffer", m_display_buffer, want.display_buffer);
                if (m_frame_ready !== want.frame_ready)
                    report_mismatch("frame_ready", m_frame_ready, want.frame_ready);
                if (m_field_number !== want.field_number)
                    report_mismatch("field_number", m_field_number, want.field_number);
                if (m_flipped !== want.flipped)
                    report_mismatch("flipped", m_flipped, want.flipped);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int directed_n;
        int pick;
        bit first_field;
        bit mid_drain;

        for (int i = 0; i < 2 * GROUPS; i++) filled[i] = 1'b0;
        first_field = 1'b1;
        mid_drain   = 1'b0;

        // start wait, nothing written yet: only out-of-range reads
        pin_sample(1'b1, 1'b1, 4'hF);          // high while waiting for low
        read_group_at(GROUP_MAX);
        queue_item(rand_item(FUNC_SPARE));
        queue_item(rand_item(FUNC_DONE));
        pin_sample(1'b0, 1'b0, 4'h0);
        pin_sample(1'b1, 1'b0, 4'hF);
        pin_sample(1'b1, 1'b1, 4'hF);          // ends the wait, not captured
        // field 0
        pin_sample(1'b1, 1'b1, 4'hF);
        pin_sample(1'b0, 1'b1, 4'h0);
        pin_sample(1'b1, 1'b1, 4'hA);
        pin_sample(1'b0, 1'b1, 4'h0);
        pin_sample(1'b1, 1'b1, 4'h5);
        // field 1, last edge lands with the polarity change
        pin_sample(1'b0, 1'b0, 4'h0);
        pin_sample(1'b1, 1'b0, 4'hF);
        pin_sample(1'b0, 1'b0, 4'h0);
        pin_sample(1'b1, 1'b1, 4'hF);
        // field 2, then swap
        pin_sample(1'b0, 1'b1, 4'h0);
        pin_sample(1'b1, 1'b1, 4'hF);
        pin_sample(1'b0, 1'b0, 4'h0);
        read_group_at(0);
        read_group_at(2);
        read_group_at(GROUPS);
        // a whole frame of empty fields while busy: swap refused
        pin_sample(1'b0, 1'b1, 4'h0);
        pin_sample(1'b0, 1'b0, 4'h0);
        pin_sample(1'b0, 1'b1, 4'h0);
        queue_item(rand_item(FUNC_DONE));
        directed_n = item_q.size();

        drain_next = 1'b1;
        while (item_q.size() < directed_n + RANDOM_ITEMS) begin
            if (!mid_drain && item_q.size() >= directed_n + RANDOM_ITEMS / 2) begin
                mid_drain  = 1'b1;
                drain_next = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (first_field) begin
                first_field = 1'b0;
                capture_field(GROUPS + 3);     // runs the pointer past the end
            end else if (pick < 70) begin
                capture_field(pick < 60 ? $urandom_range(1, GROUPS)
                                        : $urandom_range(GROUPS + 1, GROUPS + 4));
            end else if (pick < 82) begin
                rand_read();
            end else if (pick < 88) begin
                queue_item(rand_item(FUNC_DONE));
            end else if (pick < 97) begin
                pin_sample(1'($urandom), 1'($urandom), PIXELS_W'($urandom));
            end else begin
                queue_item(rand_item(FUNC_SPARE));
            end
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (item_q.size() == 0 && !s_valid && awaited_status.size() == 0);
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
